// File: design/fdp_pkg.sv
// Shared constants, coefficient table and interface structs for the FIR decimator / packer.
// No dependencies; every other design file refers to this package by scoped names.
`timescale 1ns / 1ps

package fdp_pkg;

  localparam int TAPS        = 51;
  localparam int SAMPLE_BITS = 12;
  localparam int COEF_BITS   = 16;

  localparam int COEF_COUNT   = 51;
  localparam int FRAC_BITS    = COEF_BITS - 1;
  localparam int MAX_CODE     = (1 << SAMPLE_BITS) - 1;
  localparam int TAP_IDX_BITS = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int FILL_BITS    = $clog2(TAPS + 1);
  localparam int PROD_BITS    = COEF_BITS + SAMPLE_BITS + 1;
  localparam int ACC_BITS     = PROD_BITS + $clog2(TAPS) + 1;
  localparam int ROUND_HALF   = 1 << (FRAC_BITS - 1);

  localparam int PAIRS_BITS   = 7;
  localparam int PAIRS_MAX    = 85;
  localparam int COUNT_BITS   = 8;
  localparam int ADDR_BITS    = 3;
  localparam int DATA_BITS    = 32;

  // Register indexes, taken from paddr[2]
  localparam logic REG_FILTER_ENABLE = 1'b0;
  localparam logic REG_PACKET_PAIRS  = 1'b1;

  // Rescaling of the Q1.15 set to COEF_BITS-1 fraction bits
  localparam int COEF_UP  = (COEF_BITS >= 16) ? COEF_BITS - 16 : 0;
  localparam int COEF_DN  = (COEF_BITS < 16) ? 16 - COEF_BITS : 0;
  localparam int COEF_RND = (COEF_DN > 0) ? (1 << (COEF_DN - 1)) : 0;

  localparam int COEF_Q15 [COEF_COUNT] = '{
    454, 665, 21, -1321, -2020, -1199, 138, 321, -568, -822,
    142, 759, -81, -968, -212, 1072, 532, -1214, -1045, 1321,
    1870, -1409, -3612, 1462, 11606, 16904, 11606, 1462, -3612, -1409,
    1870, -1321, -1045, -1214, 532, 1072, -212, -968, -81, 759,
    142, -822, -568, 321, 138, -1199, -2020, -1321, 21, 665,
    454
  };

  function automatic logic signed [COEF_BITS-1:0] coef_at(input int idx);
    int t;
    if (idx >= COEF_COUNT) begin
      return '0;
    end
    t = COEF_Q15[idx] <<< COEF_UP;
    t = (t + COEF_RND) >>> COEF_DN;
    return COEF_BITS'(t);
  endfunction

  // One tap read issued to the MAC pipeline
  typedef struct packed {
    logic                    valid;
    logic                    live;   // tap has been written since reset
    logic                    clear;  // zero the accumulator
    logic [TAP_IDX_BITS-1:0] tap;    // age of the tap, 0 = newest
  } mac_issue_t;

  // Kept value handed to the packer
  typedef struct packed {
    logic                   valid;
    logic [SAMPLE_BITS-1:0] value;
  } pack_req_t;

endpackage

// File: design/fdp_tap_ram.sv
// Tap history memory: one write port, one read port with registered read data.
// Depends on fdp_pkg for depth and widths.
`timescale 1ns / 1ps

module fdp_tap_ram (
  input  logic                            clk,
  input  logic                            we,
  input  logic [fdp_pkg::TAP_IDX_BITS-1:0] waddr,
  input  logic [fdp_pkg::SAMPLE_BITS-1:0]  wdata,
  input  logic                            re,
  input  logic [fdp_pkg::TAP_IDX_BITS-1:0] raddr,
  output logic [fdp_pkg::SAMPLE_BITS-1:0]  rdata
);

  logic [fdp_pkg::SAMPLE_BITS-1:0] mem [fdp_pkg::TAPS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/fdp_mac.sv
// Shared multiply-accumulate pipeline with rounding and clamping of the sum.
// Depends on fdp_pkg for the coefficient table, widths and mac_issue_t.
`timescale 1ns / 1ps

module fdp_mac (
  input  logic                            clk,
  input  logic                            rst,
  input  fdp_pkg::mac_issue_t             issue,
  input  logic [fdp_pkg::SAMPLE_BITS-1:0]  rd_data,
  output logic                            busy,
  output logic [fdp_pkg::SAMPLE_BITS-1:0]  result
);

  logic                                  valid1;
  logic                                  live1;
  logic signed [fdp_pkg::COEF_BITS-1:0]  coef1;
  logic                                  valid2;
  logic signed [fdp_pkg::PROD_BITS-1:0]  prod;
  logic signed [fdp_pkg::ACC_BITS-1:0]   acc;
  logic signed [fdp_pkg::ACC_BITS:0]     rsum;
  logic signed [fdp_pkg::ACC_BITS:0]     shifted;
  logic [fdp_pkg::SAMPLE_BITS-1:0]       tap_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
      valid2 <= 1'b0;
    end else begin
      valid1 <= issue.valid;
      valid2 <= valid1;
    end
  end

  // Coefficient is registered to line up with the registered RAM data, in the cycle after the issue
  always_ff @(posedge clk) begin
    live1 <= issue.live;
    coef1 <= fdp_pkg::coef_at(int'(issue.tap));
  end

  // Unwritten taps read as zero
  assign tap_val = live1 ? rd_data : '0;

  always_ff @(posedge clk) begin
    prod <= coef1 * $signed({1'b0, tap_val});
  end

  always_ff @(posedge clk) begin
    if (issue.clear) begin
      acc <= '0;
    end else if (valid2) begin
      acc <= acc + fdp_pkg::ACC_BITS'(prod);
    end
  end

  assign busy = valid1 | valid2;

  // Round half up, drop the fraction, clamp to the code range
  always_comb begin
    rsum    = $signed({acc[fdp_pkg::ACC_BITS-1], acc})
              + (fdp_pkg::ACC_BITS + 1)'(fdp_pkg::ROUND_HALF);
    shifted = rsum >>> fdp_pkg::FRAC_BITS;
    if (rsum < 0) begin
      result = '0;
    end else if (shifted > $signed((fdp_pkg::ACC_BITS + 1)'(fdp_pkg::MAX_CODE))) begin
      result = fdp_pkg::SAMPLE_BITS'(fdp_pkg::MAX_CODE);
    end else begin
      result = shifted[fdp_pkg::SAMPLE_BITS-1:0];
    end
  end

endmodule

// File: design/fdp_packer.sv
// Pair packer: three big-endian bytes per value pair, packet framing, output register.
// Depends on fdp_pkg for widths, packet limits and pack_req_t.
`timescale 1ns / 1ps

module fdp_packer (
  input  logic                            clk,
  input  logic                            rst,
  input  fdp_pkg::pack_req_t              req,
  output logic                            req_ready,
  input  logic [fdp_pkg::PAIRS_BITS-1:0]   packet_pairs,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      out_byte,
  output logic                            packet_last,
  output logic                            packet_buffer
);

  logic                             busy;
  logic                             sel;
  logic [fdp_pkg::SAMPLE_BITS-1:0]  value;
  logic                             pair_phase;
  logic [3:0]                       held_nibble;
  logic [fdp_pkg::COUNT_BITS-1:0]   bytes_in_packet;
  logic                             buffer_index;

  logic                             load;
  logic                             step_end;
  logic [7:0]                       byte_next;
  logic [fdp_pkg::PAIRS_BITS-1:0]   pairs;
  logic [fdp_pkg::COUNT_BITS:0]     limit;
  logic [fdp_pkg::COUNT_BITS:0]     total;
  logic                             pkt_end;

  assign req_ready = !busy;
  assign load      = busy && (!out_valid || out_ready);
  assign step_end  = !pair_phase || sel;

  always_comb begin
    if (!pair_phase) begin
      byte_next = value[11:4];
    end else if (sel) begin
      byte_next = value[7:0];
    end else begin
      byte_next = {held_nibble, value[11:8]};
    end
  end

  always_comb begin
    if (packet_pairs == '0) begin
      pairs = fdp_pkg::PAIRS_BITS'(1);
    end else if (packet_pairs > fdp_pkg::PAIRS_BITS'(fdp_pkg::PAIRS_MAX)) begin
      pairs = fdp_pkg::PAIRS_BITS'(fdp_pkg::PAIRS_MAX);
    end else begin
      pairs = packet_pairs;
    end
    limit   = (fdp_pkg::COUNT_BITS + 1)'(pairs) * (fdp_pkg::COUNT_BITS + 1)'(3);
    total   = {1'b0, bytes_in_packet} + (pair_phase ? (fdp_pkg::COUNT_BITS + 1)'(2)
                                                    : (fdp_pkg::COUNT_BITS + 1)'(1));
    pkt_end = total >= limit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy            <= 1'b0;
      sel             <= 1'b0;
      pair_phase      <= 1'b0;
      held_nibble     <= '0;
      bytes_in_packet <= '0;
      buffer_index    <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (req.valid && !busy) begin
        busy <= 1'b1;
        sel  <= 1'b0;
      end
      if (load) begin
        out_valid <= 1'b1;
        if (step_end) begin
          busy        <= 1'b0;
          pair_phase  <= !pair_phase;
          held_nibble <= pair_phase ? 4'h0 : value[3:0];
          if (pkt_end) begin
            bytes_in_packet <= '0;
            buffer_index    <= !buffer_index;
          end else begin
            bytes_in_packet <= total[fdp_pkg::COUNT_BITS-1:0];
          end
        end else begin
          sel <= 1'b1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && !busy) begin
      value <= req.value;
    end
    if (load) begin
      out_byte      <= byte_next;
      packet_last   <= step_end && pkt_end;
      packet_buffer <= buffer_index;
    end
  end

endmodule

// File: design/fir_decimate_pack12_core.sv
// Top level: FIR decimate-by-two filter with 12-bit pair packing into bytes.
// Depends on fdp_pkg, fdp_tap_ram, fdp_mac and fdp_packer.
//
//   channel   direction  signals                                 transfer when
//   input     in         in_valid, in_ready, adc_code            in_valid & in_ready
//   output    out        out_valid, out_ready, out_byte,         out_valid & out_ready
//                        packet_last, packet_buffer
//   config    in/out     psel, penable, pwrite, paddr, pwdata,   psel & penable & pwrite
//                        prdata, pready
//
// Flow: a dropped (odd) sample is only written to the tap RAM; a kept sample in bypass
// goes straight to the packer hand-over; a kept filtered sample passes the single shared
// MAC, which reads one tap a cycle from the tap RAM, then the pipeline drain and hand-over.
// Reset: synchronous; the tap RAM is not swept, a fill count makes unwritten taps read as
// zero, so input is taken from the first cycle after reset.
// Stalls: the output register holds a byte until it is taken; input is still accepted
// meanwhile, but a kept value waits for the packer while it still holds a byte of the
// previous value, and no input is accepted until that hand-over completes.
`timescale 1ns / 1ps

module fir_decimate_pack12_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [fdp_pkg::SAMPLE_BITS-1:0]  adc_code,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      out_byte,
  output logic                            packet_last,
  output logic                            packet_buffer,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fdp_pkg::ADDR_BITS-1:0]    paddr,
  input  logic [fdp_pkg::DATA_BITS-1:0]    pwdata,
  output logic [fdp_pkg::DATA_BITS-1:0]    prdata,
  output logic                            pready
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MAC,
    S_DRAIN,
    S_PACK
  } state_t;

  state_t                             state;
  logic                               filter_enable;
  logic [fdp_pkg::PAIRS_BITS-1:0]     packet_pairs;
  logic [fdp_pkg::TAP_IDX_BITS-1:0]   wr_ptr;
  logic [fdp_pkg::TAP_IDX_BITS-1:0]   rd_ptr;
  logic [fdp_pkg::TAP_IDX_BITS-1:0]   tap_age;
  logic [fdp_pkg::FILL_BITS-1:0]      fill;
  logic                               decim_phase;
  logic [fdp_pkg::SAMPLE_BITS-1:0]    value;

  logic                               in_xfer;
  logic                               cfg_wr;
  logic [fdp_pkg::SAMPLE_BITS-1:0]    rd_data;
  logic                               mac_busy;
  logic [fdp_pkg::SAMPLE_BITS-1:0]    mac_result;
  fdp_pkg::mac_issue_t                issue;
  fdp_pkg::pack_req_t                 req;
  logic                               req_ready;

  assign in_ready = (state == S_IDLE);
  assign in_xfer  = in_valid && in_ready;

  // Configuration port: zero wait states, register chosen by paddr[2]
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_enable <= 1'b1;
      packet_pairs  <= fdp_pkg::PAIRS_BITS'(10);
    end else if (cfg_wr) begin
      case (paddr[2])
        fdp_pkg::REG_FILTER_ENABLE: filter_enable <= pwdata[0];
        fdp_pkg::REG_PACKET_PAIRS:  packet_pairs  <= pwdata[fdp_pkg::PAIRS_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      fdp_pkg::REG_FILTER_ENABLE: prdata = fdp_pkg::DATA_BITS'(filter_enable);
      fdp_pkg::REG_PACKET_PAIRS:  prdata = fdp_pkg::DATA_BITS'(packet_pairs);
      default:                    prdata = '0;
    endcase
  end

  // Tap reads walk from the newest sample backwards; taps older than the fill count
  // have not been written since reset and are masked to zero in the MAC
  always_comb begin
    issue.valid = (state == S_MAC);
    issue.live  = fdp_pkg::FILL_BITS'(tap_age) < fill;
    issue.clear = in_xfer && !decim_phase && filter_enable;
    issue.tap   = tap_age;
  end

  assign req.valid = (state == S_PACK);
  assign req.value = value;

  // Sequencer: hold state, pointers and the kept value
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      wr_ptr      <= '0;
      rd_ptr      <= '0;
      tap_age     <= '0;
      fill        <= '0;
      decim_phase <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            // advance the circular write pointer; the new sample is the newest tap
            wr_ptr <= (wr_ptr == fdp_pkg::TAP_IDX_BITS'(fdp_pkg::TAPS - 1))
                      ? '0 : wr_ptr + 1'b1;
            rd_ptr <= wr_ptr;
            if (fill != fdp_pkg::FILL_BITS'(fdp_pkg::TAPS)) begin
              fill <= fill + 1'b1;
            end
            if (decim_phase) begin
              // drop odd samples after shifting them in
              decim_phase <= 1'b0;
            end else begin
              decim_phase <= 1'b1;
              if (filter_enable) begin
                tap_age <= '0;
                state   <= S_MAC;
              end else begin
                value <= adc_code;
                state <= S_PACK;
              end
            end
          end
        end
        S_MAC: begin
          rd_ptr  <= (rd_ptr == '0) ? fdp_pkg::TAP_IDX_BITS'(fdp_pkg::TAPS - 1)
                                    : rd_ptr - 1'b1;
          tap_age <= tap_age + 1'b1;
          if (tap_age == fdp_pkg::TAP_IDX_BITS'(fdp_pkg::TAPS - 1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          // wait for the last product to land in the accumulator
          if (!mac_busy) begin
            value <= mac_result;
            state <= S_PACK;
          end
        end
        S_PACK: begin
          if (req_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  fdp_tap_ram u_ram (
    .clk   (clk),
    .we    (in_xfer),
    .waddr (wr_ptr),
    .wdata (adc_code),
    .re    (state == S_MAC),
    .raddr (rd_ptr),
    .rdata (rd_data)
  );

  fdp_mac u_mac (
    .clk     (clk),
    .rst     (rst),
    .issue   (issue),
    .rd_data (rd_data),
    .busy    (mac_busy),
    .result  (mac_result)
  );

  fdp_packer u_pack (
    .clk           (clk),
    .rst           (rst),
    .req           (req),
    .req_ready     (req_ready),
    .packet_pairs  (packet_pairs),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .packet_last   (packet_last),
    .packet_buffer (packet_buffer)
  );

endmodule

// File: design/fdp_checker.sv
// Port-level checker for fir_decimate_pack12_core, attached by the bind below.
// Depends on fdp_pkg for port widths.
`timescale 1ns / 1ps

module fdp_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic [fdp_pkg::SAMPLE_BITS-1:0]  adc_code,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [7:0]                      out_byte,
  input logic                            packet_last,
  input logic                            packet_buffer,
  input logic                            psel,
  input logic                            penable,
  input logic                            pwrite,
  input logic [fdp_pkg::ADDR_BITS-1:0]    paddr,
  input logic [fdp_pkg::DATA_BITS-1:0]    pwdata,
  input logic [fdp_pkg::DATA_BITS-1:0]    prdata,
  input logic                            pready
);

  // A stalled byte holds with its framing bits
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte)
      && $stable(packet_last) && $stable(packet_buffer))
    else $error("stalled output byte changed");

  // Reset empties the output and leaves the block ready for input
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("state after reset wrong");

  // A packet size write reads back on the next cycle
  a_pairs_rb: assert property (@(posedge clk)
    !rst && psel && penable && pwrite && pready && paddr[2]
      |=> rst || !psel || pwrite || !paddr[2]
        || prdata[fdp_pkg::PAIRS_BITS-1:0] == $past(pwdata[fdp_pkg::PAIRS_BITS-1:0]))
    else $error("packet_pairs read-back mismatch");

  // Read data carries no bits above the widest register
  a_rd_upper: assert property (@(posedge clk) disable iff (rst)
    psel && !pwrite |-> prdata[fdp_pkg::DATA_BITS-1:fdp_pkg::PAIRS_BITS] == '0)
    else $error("unused read data bits set");

endmodule

bind fir_decimate_pack12_core fdp_checker u_chk (.*);

// File: verif/tb_top.sv
// Self-checking bench for fir_decimate_pack12_core: filters, decimates and packs ADC codes.
// Uses fdp_pkg for port widths and register indexes; an internal scoreboard predicts every byte.
`timescale 1ns / 1ps

module tb_top;

  localparam int          TAP_COUNT     = 51;
  localparam int          FRAC          = 15;
  localparam int          CODE_MAX      = 4095;
  localparam int          PAIRS_CAP     = 85;
  localparam int          DIRECTED_N    = 24;
  localparam int          TOTAL_ITEMS   = DIRECTED_N + 850;
  // Leave margin for a kept filtered sample to clear the MAC before touching registers.
  localparam int          SETTLE_CYCLES = 80;
  localparam int          RX_HOLD       = 500;
  localparam int unsigned CYCLE_LIMIT   = 600000;

  // Low-pass set in Q1.15; with 16-bit coefficients no rescaling is needed.
  localparam int LOWPASS_Q15 [TAP_COUNT] = '{
    454, 665, 21, -1321, -2020, -1199, 138, 321, -568, -822,
    142, 759, -81, -968, -212, 1072, 532, -1214, -1045, 1321,
    1870, -1409, -3612, 1462, 11606, 16904, 11606, 1462, -3612, -1409,
    1870, -1321, -1045, -1214, 532, 1072, -212, -968, -81, 759,
    142, -822, -568, 321, 138, -1199, -2020, -1321, 21, 665,
    454
  };

  typedef struct {
    bit [7:0] data;
    bit       last;
    bit       bufsel;
  } packed_byte_t;

  // Predicts the byte stream and checks each output transfer against it.
  class pack_scoreboard;
    bit [11:0]    taps [TAP_COUNT];
    bit           drop_next;
    bit           second_of_pair;
    bit [3:0]     held;
    int unsigned  byte_count;
    bit           buffer_sel;
    bit           filt_en;
    bit [6:0]     pairs_cfg;
    packed_byte_t pending [$];
    int           errors;

    function new();
      foreach (taps[i]) taps[i] = '0;
      drop_next      = 1'b0;
      second_of_pair = 1'b0;
      held           = '0;
      byte_count     = 0;
      buffer_sel     = 1'b0;
      filt_en        = 1'b1;
      pairs_cfg      = 7'd10;
      errors         = 0;
    endfunction

    function bit [11:0] filtered_value();
      longint acc;
      acc = 0;
      for (int i = 0; i < TAP_COUNT; i++)
        acc += longint'(LOWPASS_Q15[i]) * longint'(taps[i]);
      acc += longint'(1) << (FRAC - 1);
      if (acc < 0) return '0;
      acc = acc >>> FRAC;
      if (acc > CODE_MAX) return CODE_MAX[11:0];
      return acc[11:0];
    endfunction

    function void note_input(bit [11:0] code);
      bit [11:0]    v;
      int           n;
      int unsigned  pairs;
      packed_byte_t e [2];
      for (int i = TAP_COUNT - 1; i > 0; i--) taps[i] = taps[i-1];
      taps[0] = code;
      if (drop_next) begin
        drop_next = 1'b0;
        return;
      end
      drop_next = 1'b1;
      v = filt_en ? filtered_value() : code;
      if (!second_of_pair) begin
        e[0].data      = v[11:4];
        held           = v[3:0];
        second_of_pair = 1'b1;
        n              = 1;
      end else begin
        e[0].data      = {held, v[11:8]};
        e[1].data      = v[7:0];
        held           = '0;
        second_of_pair = 1'b0;
        n              = 2;
      end
      for (int i = 0; i < n; i++) begin
        e[i].last   = 1'b0;
        e[i].bufsel = buffer_sel;
      end
      pairs = pairs_cfg;
      if (pairs < 1) pairs = 1;
      if (pairs > PAIRS_CAP) pairs = PAIRS_CAP;
      byte_count += n;
      if (byte_count >= pairs * 3) begin
        byte_count    = 0;
        e[n-1].last   = 1'b1;
        buffer_sel    = ~buffer_sel;
      end
      for (int i = 0; i < n; i++) pending.push_back(e[i]);
    endfunction

    function void check_byte(bit [7:0] data, bit last, bit bufsel);
      packed_byte_t e;
      if (pending.size() == 0) begin
        $error("unexpected byte %02h with no expectation waiting", data);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (data !== e.data) begin
        $error("out_byte mismatch: expected %02h actual %02h", e.data, data);
        errors++;
      end
      if (last !== e.last) begin
        $error("packet_last mismatch: expected %0d actual %0d", e.last, last);
        errors++;
      end
      if (bufsel !== e.bufsel) begin
        $error("packet_buffer mismatch: expected %0d actual %0d", e.bufsel, bufsel);
        errors++;
      end
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [fdp_pkg::SAMPLE_BITS-1:0] adc_code = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [7:0]                      out_byte;
  logic                            packet_last;
  logic                            packet_buffer;
  logic                            psel = 1'b0;
  logic                            penable = 1'b0;
  logic                            pwrite = 1'b0;
  logic [fdp_pkg::ADDR_BITS-1:0]   paddr = '0;
  logic [fdp_pkg::DATA_BITS-1:0]   pwdata = '0;
  logic [fdp_pkg::DATA_BITS-1:0]   prdata;
  logic                            pready;

  pack_scoreboard sb = new();
  int unsigned    tx_count = 0;
  int unsigned    cycles = 0;
  int             rx_hold = 0;
  bit             tx_steady = 1'b0;
  bit             rx_steady = 1'b0;

  fir_decimate_pack12_core DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .adc_code      (adc_code),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .packet_last   (packet_last),
    .packet_buffer (packet_buffer),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: give up if the run hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[fir_decimate_pack12_core] ERROR");
      $finish;
    end
  end

  // Monitor both channels on the rising edge. An output transfer always belongs to an
  // earlier input, so check it before noting the input of the same edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_byte(out_byte, packet_last, packet_buffer);
      if (in_valid && in_ready) sb.note_input(adc_code);
    end
  end

  // Output side: random stalls per transfer, steady stretches now and then, and a long
  // hold-off when the stimulus asks for one so that the block backs up into its input.
  initial begin : rx_side
    int stall;
    while (rst) @(negedge clk);
    forever begin
      if (rx_hold > 0) begin
        out_ready = 1'b0;
        repeat (rx_hold) @(negedge clk);
        rx_hold = 0;
      end
      if ($urandom_range(0, 29) == 0) rx_steady = ~rx_steady;
      stall = rx_steady ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Offer one code after a random gap; return at the falling edge after its transfer,
  // with valid still high so that a gapless follow-up keeps it asserted.
  task automatic send_code(input bit [11:0] code);
    int gap;
    if ($urandom_range(0, 39) == 0) tx_steady = ~tx_steady;
    gap = tx_steady ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    adc_code = code;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    tx_count++;
  endtask

  // Drop valid, wait for every expected byte, then wait out a settling margin.
  task automatic wait_drained();
    in_valid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write one register, read it back, and mirror it into the prediction.
  task automatic write_reg(input logic reg_idx, input bit [31:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {reg_idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    pwrite  = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== value) begin
      $error("register %0d read-back mismatch: expected %0h actual %0h",
             reg_idx, value, prdata);
      sb.errors++;
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    if (reg_idx == fdp_pkg::REG_FILTER_ENABLE) sb.filt_en = value[0];
    else sb.pairs_cfg = value[6:0];
  endtask

  task automatic set_config(input bit enable, input bit [6:0] pairs);
    write_reg(fdp_pkg::REG_FILTER_ENABLE, {31'd0, enable});
    write_reg(fdp_pkg::REG_PACKET_PAIRS, {25'd0, pairs});
  endtask

  function automatic bit [6:0] pick_pairs();
    case ($urandom_range(0, 9))
      0:       return 7'd0;
      1:       return 7'd1;
      2:       return 7'd85;
      3:       return 7'd127;
      4:       return 7'($urandom_range(86, 126));
      5:       return 7'($urandom_range(13, 84));
      default: return 7'($urandom_range(1, 12));
    endcase
  endfunction

  // Lay down 51 codes that match the coefficient signs, so that the sum clamps high
  // (or low when inverted) exactly on a kept sample.
  task automatic send_clamp_pattern(input bit invert);
    bit hot;
    if (tx_count % 2 != 0) send_code(12'($urandom_range(0, CODE_MAX)));
    for (int k = 0; k < TAP_COUNT; k++) begin
      hot = (LOWPASS_Q15[TAP_COUNT-1-k] > 0) ^ invert;
      send_code(hot ? 12'hFFF : 12'h000);
    end
  endtask

  // Slowly wandering signal around a random level, as a real converter would deliver.
  task automatic send_walk(input int count);
    int lvl;
    lvl = $urandom_range(0, CODE_MAX);
    repeat (count) begin
      lvl += int'($urandom_range(0, 400)) - 200;
      if (lvl < 0) lvl = 0;
      if (lvl > CODE_MAX) lvl = CODE_MAX;
      send_code(12'(lvl));
    end
  endtask

  task automatic send_burst(output int sent);
    int count;
    count = $urandom_range(4, 30);
    case ($urandom_range(0, 5))
      0, 1: begin
        send_walk(count);
        sent = count;
      end
      2: begin
        repeat (count) send_code(12'($urandom_range(0, CODE_MAX)));
        sent = count;
      end
      3: begin
        repeat (count) send_code($urandom_range(0, 1) ? 12'hFFF : 12'h000);
        sent = count;
      end
      default: begin
        send_clamp_pattern($urandom_range(0, 1));
        sent = TAP_COUNT;
      end
    endcase
  endtask

  initial begin : stimulus
    int phase_len;
    int sent;
    int phase;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Bypass, two pairs per packet: raw extremes and alternating bit patterns.
    set_config(1'b0, 7'd2);
    send_code(12'h000); send_code(12'hFFF); send_code(12'hAAA); send_code(12'h555);
    send_code(12'h800); send_code(12'h7FF); send_code(12'h001); send_code(12'hFFE);
    wait_drained();

    // Filtered, largest packet: full-scale step then a few edge codes.
    set_config(1'b1, 7'd85);
    repeat (4) send_code(12'hFFF);
    send_code(12'h000); send_code(12'h800); send_code(12'hFFF); send_code(12'h001);
    wait_drained();

    // Shrink the packet below the bytes already counted: the next first-of-pair byte
    // closes the packet and the pair carries on in the other buffer. Zero acts as one.
    write_reg(fdp_pkg::REG_PACKET_PAIRS, 32'd0);
    send_code(12'h123); send_code(12'hFED); send_code(12'h0F0); send_code(12'hF0F);
    wait_drained();

    // Out-of-range size clamps to the maximum; back to bypass with history kept.
    set_config(1'b0, 7'd127);
    send_code(12'h3C3); send_code(12'hC3C); send_code(12'h000); send_code(12'hFFF);

    phase = 0;
    while (tx_count < TOTAL_ITEMS) begin
      wait_drained();
      if ($urandom_range(0, 3) != 0)
        set_config($urandom_range(0, 3) != 0, pick_pairs());
      // Hold the output off for a long stretch while input keeps coming.
      if (phase == 2 || phase == 9) rx_hold = RX_HOLD;
      phase_len = $urandom_range(20, 90);
      while (phase_len > 0 && tx_count < TOTAL_ITEMS) begin
        send_burst(sent);
        phase_len -= sent;
      end
      phase++;
    end

    in_valid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (sb.errors == 0) begin
      $display("[fir_decimate_pack12_core] OK");
    end else begin
      $display("[fir_decimate_pack12_core] ERROR");
    end
    $finish;
  end

endmodule
